/* rtl/core/cle_pkg.sv */
`default_nettype none

package cle_pkg;

   // Default sizes
   localparam int LINE_DEPTH_DEF = 64;
   localparam int MAX_ARGS_DEF   = 8;

   // Register map (byte address bit 2 selects the register)
   localparam logic REG_LINE_SIZE = 1'b0;
   localparam logic REG_ECHO      = 1'b1;

   localparam logic [6:0] LINE_SIZE_RST = 7'd64;
   localparam logic       ECHO_RST      = 1'b1;

   // Input word kinds
   localparam logic [1:0] KIND_RX     = 2'd0;
   localparam logic [1:0] KIND_FINISH = 2'd1;
   localparam logic [1:0] KIND_READ   = 2'd2;
   localparam logic [1:0] KIND_ACK    = 2'd3;

   // Result word kinds
   localparam logic [1:0] OUT_ECHO  = 2'd0;
   localparam logic [1:0] OUT_SPAN  = 2'd1;
   localparam logic [1:0] OUT_READ  = 2'd2;
   localparam logic [1:0] OUT_READY = 2'd3;

   // Characters
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_CTRLC = 8'h03;
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TILDE = 8'h7E;
   localparam logic [7:0] CH_DEL   = 8'h7F;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] rx_byte;
      logic [5:0] read_index;
   } req_type;

   typedef struct packed {
      logic [1:0] out_kind;
      logic [7:0] out_byte;
      logic [5:0] arg_start;
      logic [5:0] arg_length;
      logic [4:0] arg_count;
      logic       busy_res;
      logic       stop_request;
      logic       last;
   } rsp_type;

   // Microcode
   localparam int UA_W = 5;

   typedef enum logic [2:0] {
      UOP_ECHO_K,    // echo the constant character of the word
      UOP_ECHO_RX,   // echo the received character
      UOP_READ_OUT,  // return the line byte read
      UOP_SCAN,      // one line position per cycle, loops until done
      UOP_JZ,        // jump if no arguments, else mark running
      UOP_SPAN,      // one span per result, loops over all spans
      UOP_READY      // command ready with argument count
   } uop_type;

   typedef struct packed {
      uop_type         op;
      logic [7:0]      chr;
      logic            last;
      logic            fin;
      logic [UA_W-1:0] tgt;
   } ucode_type;

   // Program entry points
   localparam logic [UA_W-1:0] ENT_CHAR   = 5'd0;
   localparam logic [UA_W-1:0] ENT_BS     = 5'd1;
   localparam logic [UA_W-1:0] ENT_READ   = 5'd4;
   localparam logic [UA_W-1:0] ENT_FINISH = 5'd5;
   localparam logic [UA_W-1:0] ENT_LINE   = 5'd13;

   typedef struct packed {
      logic            start;
      logic [UA_W-1:0] entry;
      logic            adv;
      logic            argc_zero;
   } seq_stat_type;

   typedef struct packed {
      logic      active;
      ucode_type word;
   } seq_ctl_type;

   function automatic ucode_type uw(input uop_type op, input logic [7:0] chr,
                                    input logic last, input logic fin,
                                    input logic [UA_W-1:0] tgt);
      ucode_type w;
      w.op   = op;
      w.chr  = chr;
      w.last = last;
      w.fin  = fin;
      w.tgt  = tgt;
      return w;
   endfunction

   // Control store
   function automatic ucode_type ucode_rom(input logic [UA_W-1:0] a);
      ucode_type w;
      case (a)
         // printable character
         5'd0:  w = uw(UOP_ECHO_RX,  CH_NUL,   1'b1, 1'b1, 5'd0);
         // rub out
         5'd1:  w = uw(UOP_ECHO_K,   CH_BS,    1'b0, 1'b0, 5'd0);
         5'd2:  w = uw(UOP_ECHO_K,   CH_SPACE, 1'b0, 1'b0, 5'd0);
         5'd3:  w = uw(UOP_ECHO_K,   CH_BS,    1'b1, 1'b1, 5'd0);
         // line byte read
         5'd4:  w = uw(UOP_READ_OUT, CH_NUL,   1'b1, 1'b1, 5'd0);
         // new line and prompt
         5'd5:  w = uw(UOP_ECHO_K,   CH_CR,    1'b0, 1'b0, 5'd0);
         5'd6:  w = uw(UOP_ECHO_K,   CH_LF,    1'b0, 1'b0, 5'd0);
         5'd7:  w = uw(UOP_ECHO_K,   8'h53,    1'b0, 1'b0, 5'd0);
         5'd8:  w = uw(UOP_ECHO_K,   8'h48,    1'b0, 1'b0, 5'd0);
         5'd9:  w = uw(UOP_ECHO_K,   8'h45,    1'b0, 1'b0, 5'd0);
         5'd10: w = uw(UOP_ECHO_K,   8'h4C,    1'b0, 1'b0, 5'd0);
         5'd11: w = uw(UOP_ECHO_K,   8'h4C,    1'b0, 1'b0, 5'd0);
         5'd12: w = uw(UOP_ECHO_K,   8'h3E,    1'b1, 1'b1, 5'd0);
         // end of line: tokenise, then report
         5'd13: w = uw(UOP_SCAN,     CH_NUL,   1'b0, 1'b0, 5'd0);
         5'd14: w = uw(UOP_JZ,       CH_NUL,   1'b0, 1'b0, ENT_FINISH);
         5'd15: w = uw(UOP_ECHO_K,   CH_CR,    1'b0, 1'b0, 5'd0);
         5'd16: w = uw(UOP_ECHO_K,   CH_LF,    1'b0, 1'b0, 5'd0);
         5'd17: w = uw(UOP_SPAN,     CH_NUL,   1'b0, 1'b0, 5'd0);
         5'd18: w = uw(UOP_READY,    CH_NUL,   1'b1, 1'b1, 5'd0);
         default: w = uw(UOP_ECHO_K, CH_NUL,   1'b1, 1'b1, 5'd0);
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/console_line_editor_tokenizer.sv */
`default_nettype none

// Serial console line editor. Words of kind received byte are edited into a line store
// while no command runs; carriage return (or a full line) echoes CR LF, splits the line at
// spaces and tabs into at most MAX_ARGS spans and reports them with a command-ready word, or
// shows the prompt again for an empty line. A finish word ends the command and prompts; a
// read word returns one stored byte. Control is a small microprogram, one control word per
// cycle unless a word waits for the result side or loops. An input word is taken only while
// no microprogram runs; its results then follow one per cycle while the result side keeps
// up: a character echo is one control step, a rub-out three, a read one, a finish eight.
// A line end scans the line, one stored character per cycle through the single read port
// of the line store (the scan stops early once MAX_ARGS spans are found), then takes the
// decision step, then the steps that echo CR LF and report the spans and the count.
// New input words are taken again once the last result of the word is in the output
// register. Words that give no result (Ctrl-C while busy, stop acknowledge, dropped bytes)
// are taken back to back.
module console_line_editor_tokenizer #(
   parameter int LINE_DEPTH = cle_pkg::LINE_DEPTH_DEF,
   parameter int MAX_ARGS   = cle_pkg::MAX_ARGS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire cle_pkg::req_type req_word,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output cle_pkg::rsp_type      rsp_word,
   input  wire logic             csr_psel,
   input  wire logic             csr_penable,
   input  wire logic             csr_pwrite,
   input  wire logic [2:0]       csr_paddr,
   input  wire logic [31:0]      csr_pwdata,
   output logic      [31:0]      csr_prdata,
   output logic                  csr_pready
);

   localparam int AW   = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
   localparam int SZ_W = $clog2(LINE_DEPTH + 1);
   localparam int CW   = (SZ_W > 7) ? SZ_W : 7;
   localparam int ACW  = $clog2(MAX_ARGS + 1);
   localparam int SIW  = (MAX_ARGS > 1) ? $clog2(MAX_ARGS) : 1;

   // registers
   logic [6:0]     line_size_ff, line_size_in;
   logic           echo_ff, echo_in;
   logic [AW-1:0]  pos_ff, pos_in;
   logic           run_ff, run_in;
   logic           stop_ff, stop_in;
   logic [7:0]     rx_ff, rx_in;
   logic           oob_ff, oob_in;
   logic [AW-1:0]  scan_ff, scan_in;
   logic [AW-1:0]  start_ff, start_in;
   logic           in_arg_ff, in_arg_in;
   logic [ACW-1:0] argc_ff, argc_in;
   logic [SIW-1:0] sp_ff, sp_in;
   logic [AW-1:0]  span_start_ff [MAX_ARGS];
   logic [AW-1:0]  span_len_ff [MAX_ARGS];
   cle_pkg::rsp_type rsp_ff, rsp_in;
   logic           rsp_valid_ff, rsp_valid_in;

   // line store port
   logic           ram_we;
   logic [AW-1:0]  ram_waddr;
   logic [7:0]     ram_wdata;
   logic           ram_re;
   logic [AW-1:0]  ram_raddr;
   logic [7:0]     ram_rdata;

   cle_pkg::seq_stat_type stat;
   cle_pkg::seq_ctl_type  ctl;

   logic           acc;
   logic           cfg_wr;
   logic [CW-1:0]  size_eff, ls_ext, dep_c, pos_ext;
   logic [7:0]     rx;
   logic           is_rx, is_bsc;
   logic           d_line, d_bs, d_store, d_ctrlc, d_fin, d_read, d_ack;
   logic           out_free;
   logic           sep, rec, scan_done, sp_last;
   logic [ACW-1:0] argc_plus;
   logic           span_we;
   logic           want;
   logic [1:0]     o_kind;
   logic [7:0]     o_byte;
   logic [5:0]     o_start, o_len;
   logic [4:0]     o_cnt;

   cle_ram #(
      .WIDTH (8),
      .DEPTH (LINE_DEPTH)
   ) u_line (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   cle_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctl   (ctl)
   );

   assign req_ready = !ctl.active;
   assign acc       = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // decode of the incoming word
   always_comb begin
      ls_ext   = CW'(line_size_ff);
      dep_c    = CW'(LINE_DEPTH);
      size_eff = (ls_ext > dep_c) ? dep_c : ls_ext;
      pos_ext  = CW'(pos_ff);
      rx       = req_word.rx_byte;
      is_rx    = req_word.kind == cle_pkg::KIND_RX;
      is_bsc   = rx == cle_pkg::CH_BS || rx == cle_pkg::CH_DEL;
      d_line   = is_rx && !run_ff && (rx == cle_pkg::CH_CR || pos_ext >= size_eff);
      d_bs     = is_rx && !run_ff && !d_line && is_bsc && pos_ff != '0;
      d_store  = is_rx && !run_ff && !d_line && !is_bsc && (pos_ext + CW'(1) < size_eff)
                 && rx >= cle_pkg::CH_SPACE && rx <= cle_pkg::CH_TILDE;
      d_ctrlc  = is_rx && run_ff && rx == cle_pkg::CH_CTRLC;
      d_fin    = req_word.kind == cle_pkg::KIND_FINISH && run_ff;
      d_read   = req_word.kind == cle_pkg::KIND_READ;
      d_ack    = req_word.kind == cle_pkg::KIND_ACK;
   end

   // tokeniser step
   always_comb begin
      sep       = scan_ff == pos_ff || ram_rdata == cle_pkg::CH_SPACE
                  || ram_rdata == cle_pkg::CH_TAB;
      rec       = sep && in_arg_ff;
      argc_plus = argc_ff + ACW'(1);
      scan_done = scan_ff == pos_ff || (rec && argc_plus == ACW'(MAX_ARGS));
      sp_last   = ACW'(sp_ff) + ACW'(1) == argc_ff;
   end

   // datapath under microcode control
   always_comb begin
      pos_in       = pos_ff;
      run_in       = run_ff;
      stop_in      = stop_ff;
      rx_in        = rx_ff;
      oob_in       = oob_ff;
      scan_in      = scan_ff;
      start_in     = start_ff;
      in_arg_in    = in_arg_ff;
      argc_in      = argc_ff;
      sp_in        = sp_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ram_we       = 1'b0;
      ram_waddr    = pos_ff;
      ram_wdata    = rx;
      ram_re       = 1'b0;
      ram_raddr    = AW'(req_word.read_index);
      span_we      = 1'b0;
      want         = 1'b0;
      o_kind       = cle_pkg::OUT_ECHO;
      o_byte       = cle_pkg::CH_NUL;
      o_start      = '0;
      o_len        = '0;
      o_cnt        = '0;
      stat.start   = 1'b0;
      stat.entry   = cle_pkg::ENT_CHAR;
      stat.adv     = 1'b0;
      stat.argc_zero = argc_ff == '0;

      if (ctl.active) begin
         unique case (ctl.word.op)
            cle_pkg::UOP_ECHO_K: begin
               want     = echo_ff;
               o_byte   = ctl.word.chr;
               stat.adv = !echo_ff || out_free;
            end
            cle_pkg::UOP_ECHO_RX: begin
               want     = echo_ff;
               o_byte   = rx_ff;
               stat.adv = !echo_ff || out_free;
            end
            cle_pkg::UOP_READ_OUT: begin
               want     = 1'b1;
               o_kind   = cle_pkg::OUT_READ;
               o_byte   = oob_ff ? cle_pkg::CH_NUL : ram_rdata;
               stat.adv = out_free;
            end
            cle_pkg::UOP_SCAN: begin
               stat.adv  = scan_done;
               scan_in   = scan_ff + AW'(1);
               ram_re    = 1'b1;
               ram_raddr = scan_ff + AW'(1);
               if (rec) begin
                  span_we   = 1'b1;
                  argc_in   = argc_plus;
                  in_arg_in = 1'b0;
               end else if (!sep && !in_arg_ff) begin
                  in_arg_in = 1'b1;
                  start_in  = scan_ff;
               end
            end
            cle_pkg::UOP_JZ: begin
               stat.adv = 1'b1;
               if (argc_ff == '0) begin
                  pos_in = '0;
               end else begin
                  run_in = 1'b1;
               end
            end
            cle_pkg::UOP_SPAN: begin
               want     = 1'b1;
               o_kind   = cle_pkg::OUT_SPAN;
               o_start  = 6'(span_start_ff[sp_ff]);
               o_len    = 6'(span_len_ff[sp_ff]);
               stat.adv = out_free && sp_last;
               if (out_free) begin
                  sp_in = sp_ff + SIW'(1);
               end
            end
            cle_pkg::UOP_READY: begin
               want     = 1'b1;
               o_kind   = cle_pkg::OUT_READY;
               o_cnt    = 5'(argc_ff);
               stat.adv = out_free;
            end
            default: begin
               stat.adv = 1'b1;
            end
         endcase
      end

      // load the output register
      if (ctl.active && want && out_free) begin
         rsp_valid_in        = 1'b1;
         rsp_in.out_kind     = o_kind;
         rsp_in.out_byte     = o_byte;
         rsp_in.arg_start    = o_start;
         rsp_in.arg_length   = o_len;
         rsp_in.arg_count    = o_cnt;
         rsp_in.busy_res     = run_ff;
         rsp_in.stop_request = stop_ff;
         rsp_in.last         = ctl.word.last;
      end

      // accept and dispatch
      if (acc) begin
         rx_in  = rx;
         oob_in = 32'(req_word.read_index) >= 32'(LINE_DEPTH);
         if (d_ctrlc) begin
            stop_in = 1'b1;
         end
         if (d_ack) begin
            stop_in = 1'b0;
         end
         if (d_bs) begin
            pos_in     = pos_ff - AW'(1);
            stat.start = 1'b1;
            stat.entry = cle_pkg::ENT_BS;
         end
         if (d_store) begin
            ram_we     = 1'b1;
            pos_in     = pos_ff + AW'(1);
            stat.start = 1'b1;
            stat.entry = cle_pkg::ENT_CHAR;
         end
         if (d_fin) begin
            pos_in     = '0;
            run_in     = 1'b0;
            stat.start = 1'b1;
            stat.entry = cle_pkg::ENT_FINISH;
         end
         if (d_read) begin
            ram_re     = 1'b1;
            stat.start = 1'b1;
            stat.entry = cle_pkg::ENT_READ;
         end
         if (d_line) begin
            ram_re     = 1'b1;
            ram_raddr  = '0;
            scan_in    = '0;
            in_arg_in  = 1'b0;
            argc_in    = '0;
            sp_in      = '0;
            stat.start = 1'b1;
            stat.entry = cle_pkg::ENT_LINE;
         end
      end
   end

   // configuration registers
   assign cfg_wr = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      line_size_in = line_size_ff;
      echo_in      = echo_ff;
      if (cfg_wr) begin
         unique case (csr_paddr[2])
            cle_pkg::REG_LINE_SIZE: line_size_in = csr_pwdata[6:0];
            cle_pkg::REG_ECHO:      echo_in      = csr_pwdata[0];
            default:                echo_in      = echo_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         cle_pkg::REG_LINE_SIZE: csr_prdata = {25'd0, line_size_ff};
         cle_pkg::REG_ECHO:      csr_prdata = {31'd0, echo_ff};
         default:                csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         line_size_ff <= cle_pkg::LINE_SIZE_RST;
         echo_ff      <= cle_pkg::ECHO_RST;
         pos_ff       <= '0;
         run_ff       <= 1'b0;
         stop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         line_size_ff <= line_size_in;
         echo_ff      <= echo_in;
         pos_ff       <= pos_in;
         run_ff       <= run_in;
         stop_ff      <= stop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and scan working registers
   always_ff @(posedge clock) begin
      rx_ff     <= rx_in;
      oob_ff    <= oob_in;
      scan_ff   <= scan_in;
      start_ff  <= start_in;
      in_arg_ff <= in_arg_in;
      argc_ff   <= argc_in;
      sp_ff     <= sp_in;
      rsp_ff    <= rsp_in;
      if (span_we) begin
         span_start_ff[argc_ff[SIW-1:0]] <= start_ff;
         span_len_ff[argc_ff[SIW-1:0]]   <= scan_ff - start_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

`default_nettype wire

/* rtl/core/cle_ram.sv */
`default_nettype none

// Simple dual-port RAM, registered read
module cle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                                       clock,
   input  wire logic                                       we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                           wdata,
   input  wire logic                                       re,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                           rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* rtl/core/cle_seq.sv */
`default_nettype none

// Step counter and control store with conditional jump
module cle_seq (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cle_pkg::seq_stat_type stat,
   output cle_pkg::seq_ctl_type      ctl
);

   logic                        act_ff, act_in;
   logic [cle_pkg::UA_W-1:0]    upc_ff, upc_in;
   cle_pkg::ucode_type          word;

   assign word = cle_pkg::ucode_rom(upc_ff);

   // next step
   always_comb begin
      act_in = act_ff;
      upc_in = upc_ff;
      if (stat.start) begin
         act_in = 1'b1;
         upc_in = stat.entry;
      end else if (act_ff && stat.adv) begin
         if (word.fin) begin
            act_in = 1'b0;
         end else if (word.op == cle_pkg::UOP_JZ && stat.argc_zero) begin
            upc_in = word.tgt;
         end else begin
            upc_in = upc_ff + cle_pkg::UA_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0;
         upc_ff <= '0;
      end else begin
         act_ff <= act_in;
         upc_ff <= upc_in;
      end
   end

   assign ctl.active = act_ff;
   assign ctl.word   = word;

endmodule

`default_nettype wire
